[sv/nfa_pkg.sv]
package nfa_pkg;

    // Default geometry; both must be powers of two.
    localparam int DEF_BLK_BYTES   = 256;
    localparam int DEF_BLOCK_COUNT = 64;

    localparam int QUEUE_DEPTH = 2;

    localparam int ADDR_W    = 32;
    localparam int LENGTH_W  = 15;
    localparam int CFG_ADDR_W = 3;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;

    // Register index carried by paddr[2].
    localparam logic REG_BASE_ADDRESS = 1'b0;

    typedef enum logic [1:0] {
        OP_READ      = 2'd0,
        OP_PROG      = 2'd1,
        OP_ERASE     = 2'd2,
        OP_ERASE_ALL = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [ADDR_W-1:0]   address;
        logic [7:0]          data;
        logic [LENGTH_W-1:0] length;
    } t_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] read_data;
    } t_result;

    typedef struct packed {
        logic clearing;
    } t_back_status;

endpackage

[sv/nfa_front.sv]
module nfa_front #(
    parameter int  BLK_BYTES   = nfa_pkg::DEF_BLK_BYTES,
    parameter int  BLOCK_COUNT = nfa_pkg::DEF_BLOCK_COUNT,
    parameter type t_cmd       = logic
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  nfa_pkg::t_item        i_item,
    input  logic [31:0]           i_base_address,
    input  nfa_pkg::t_back_status i_status,
    input  logic                  i_q_full,
    output logic                  o_busy,
    output logic                  o_push,
    output t_cmd                  o_cmd
);
    import nfa_pkg::*;

    localparam int ARRAY_BYTES = BLK_BYTES * BLOCK_COUNT;
    localparam int AW          = $clog2(ARRAY_BYTES);
    localparam int EW          = ((AW > LENGTH_W) ? AW : LENGTH_W) + 1;
    localparam logic [AW-1:0] BLK_MASK = AW'(BLK_BYTES - 1);
    localparam logic [AW-1:0] LAST_OFF = AW'(ARRAY_BYTES - 1);

    logic                r_valid;
    logic                n_valid;
    t_op                 r_op;
    logic [ADDR_W:0]     r_diff;
    logic [7:0]          r_data;
    logic [LENGTH_W-1:0] r_length;

    logic                w_accept;
    logic                w_in_win;
    logic [AW-1:0]       w_off;
    logic [EW-1:0]       w_last_byte;

    assign o_busy   = i_status.clearing || (r_valid && i_q_full);
    assign o_push   = r_valid && !i_q_full;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Hold the word and its offset from the window base.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op     <= i_item.op;
            r_diff   <= {1'b0, i_item.address} - {1'b0, i_base_address};
            r_data   <= i_item.data;
            r_length <= i_item.length;
        end
    end

    assign w_in_win    = !r_diff[ADDR_W] && (r_diff[ADDR_W-1:0] < ADDR_W'(ARRAY_BYTES));
    assign w_off       = r_diff[AW-1:0];
    assign w_last_byte = EW'(w_off) + EW'(r_length) - EW'(1);

    // Classify: window check and block span of an erase.
    always_comb begin
        o_cmd       = '0;
        o_cmd.op    = r_op;
        o_cmd.data  = r_data;
        o_cmd.first = w_off;
        o_cmd.last  = w_off;
        o_cmd.hit   = w_in_win;
        o_cmd.empty = 1'b0;
        unique case (r_op) inside
            OP_ERASE_ALL: begin
                o_cmd.hit   = 1'b1;
                o_cmd.first = '0;
                o_cmd.last  = LAST_OFF;
            end
            OP_ERASE: begin
                o_cmd.empty = (r_length == '0);
                o_cmd.first = w_off & ~BLK_MASK;
                if (w_last_byte >= EW'(ARRAY_BYTES)) begin
                    o_cmd.last = LAST_OFF;
                end else begin
                    o_cmd.last = w_last_byte[AW-1:0] | BLK_MASK;
                end
            end
            OP_READ, OP_PROG: begin
                o_cmd.first = w_off;
            end
        endcase
    end

endmodule

[sv/nfa_queue.sv]
module nfa_queue #(
    parameter type t_cmd = logic,
    parameter int  DEPTH = nfa_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);
    import nfa_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_entry [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [PW-1:0] n_wr_ptr;
    logic [PW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;

    assign o_cmd   = r_entry[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[sv/nfa_back.sv]
module nfa_back #(
    parameter int  BLK_BYTES   = nfa_pkg::DEF_BLK_BYTES,
    parameter int  BLOCK_COUNT = nfa_pkg::DEF_BLOCK_COUNT,
    parameter type t_cmd       = logic
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic                  i_q_empty,
    output logic                  o_pop,
    output logic                  o_done,
    output nfa_pkg::t_result      o_result,
    output nfa_pkg::t_back_status o_status
);
    import nfa_pkg::*;

    localparam int ARRAY_BYTES = BLK_BYTES * BLOCK_COUNT;
    localparam int AW          = $clog2(ARRAY_BYTES);
    localparam logic [AW-1:0] LAST_OFF = AW'(ARRAY_BYTES - 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_PROG  = 4'b0100,
        ST_SWEEP = 4'b1000
    } t_state;

    t_state        r_state;
    t_state        n_state;
    logic [AW-1:0] r_ptr;
    logic [AW-1:0] n_ptr;
    logic [AW-1:0] r_last;
    logic [AW-1:0] n_last;
    logic [7:0]    r_data;
    logic [7:0]    n_data;
    logic          r_report;
    logic          n_report;
    logic          r_done;
    logic          n_done;
    t_result       r_result;
    t_result       n_result;
    logic [7:0]    r_rdata;

    logic [7:0]    mem [ARRAY_BYTES];
    logic          w_mem_re;
    logic          w_mem_we;
    logic [AW-1:0] w_mem_addr;
    logic [7:0]    w_mem_wdata;

    assign o_done            = r_done;
    assign o_result          = r_result;
    assign o_status.clearing = (r_state == ST_SWEEP) && !r_report;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_last      = r_last;
        n_data      = r_data;
        n_report    = r_report;
        n_done      = 1'b0;
        n_result    = '0;
        o_pop       = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_addr  = r_ptr;
        w_mem_wdata = ERASED_BYTE;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_pop      = 1'b1;
                    w_mem_addr = i_cmd.first;
                    if (!i_cmd.hit) begin
                        n_done = 1'b1;
                    end else begin
                        unique case (i_cmd.op) inside
                            OP_READ: begin
                                w_mem_re = 1'b1;
                                n_state  = ST_READ;
                            end
                            OP_PROG: begin
                                w_mem_re = 1'b1;
                                n_ptr    = i_cmd.first;
                                n_data   = i_cmd.data;
                                n_state  = ST_PROG;
                            end
                            OP_ERASE, OP_ERASE_ALL: begin
                                if (i_cmd.empty) begin
                                    n_done      = 1'b1;
                                    n_result.ok = 1'b1;
                                end else begin
                                    n_ptr    = i_cmd.first;
                                    n_last   = i_cmd.last;
                                    n_report = 1'b1;
                                    n_state  = ST_SWEEP;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_READ: begin
                n_done             = 1'b1;
                n_result.ok        = 1'b1;
                n_result.read_data = r_rdata;
                n_state            = ST_IDLE;
            end
            ST_PROG: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = r_rdata & r_data;
                n_done      = 1'b1;
                n_result.ok = 1'b1;
                n_state     = ST_IDLE;
            end
            ST_SWEEP: begin
                w_mem_we = 1'b1;
                if (r_ptr == r_last) begin
                    n_done      = r_report;
                    n_result.ok = r_report;
                    n_report    = 1'b0;
                    n_state     = ST_IDLE;
                end else begin
                    n_ptr = r_ptr + AW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Reset starts an unreported sweep over the whole array.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_SWEEP;
            r_ptr    <= '0;
            r_last   <= LAST_OFF;
            r_report <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_last   <= n_last;
            r_report <= n_report;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data   <= n_data;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[w_mem_addr] <= w_mem_wdata;
        end
        if (w_mem_re) begin
            r_rdata <= mem[w_mem_addr];
        end
    end

endmodule

[sv/nor_flash_array_model_core.sv]
// Channel   Direction  Handshake                         Payload
// -------   ---------  --------------------------------  ------------------------------
// command   in         start high and busy low           i_item   (op, address, data,
//                                                                  length)
// result    out        o_done high for one cycle         o_result (ok, read_data)
// config    in         APB: psel, penable, pwrite,       pwdata -> base_address
//                      pready (always high)              (paddr[2] low), prdata back
//
// A word is registered in the front stage and then waits in the queue for the back stage.
// Out-of-window words and zero-length erases are answered from the back's idle state,
// reads pass ST_READ and programs ST_PROG. An erase sweeps every byte of each block it touches
// (BLK_BYTES bytes per block), erase-all BLK_BYTES * BLOCK_COUNT: the single byte port sets the pace.
// After reset a clearing pass writes 0xFF over all BLK_BYTES * BLOCK_COUNT bytes with busy high.
// The receiver cannot stall; busy also rises while the queue is full and the front holds a word.
module nor_flash_array_model_core #(
    parameter int BLK_BYTES   = nfa_pkg::DEF_BLK_BYTES,
    parameter int BLOCK_COUNT = nfa_pkg::DEF_BLOCK_COUNT
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  nfa_pkg::t_item                 i_item,
    output logic                           o_done,
    output nfa_pkg::t_result               o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nfa_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import nfa_pkg::*;

    // Byte offset width of the array.
    localparam int AW = $clog2(BLK_BYTES * BLOCK_COUNT);

    // Classified word passed from front to back. first/last give the
    // byte span: the offset for read and program, whole blocks for erase.
    typedef struct packed {
        t_op           op;
        logic          hit;
        logic          empty;
        logic [AW-1:0] first;
        logic [AW-1:0] last;
        logic [7:0]    data;
    } t_cmd;

    logic [31:0]  r_base_address;
    logic         w_cfg_write;
    logic         w_push;
    logic         w_pop;
    logic         w_q_full;
    logic         w_q_empty;
    t_cmd         w_front_cmd;
    t_cmd         w_back_cmd;
    t_back_status w_status;

    // Configuration port: single register, no wait states.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign prdata      = (paddr[2] == REG_BASE_ADDRESS) ? r_base_address : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_address <= '0;
        end else if (w_cfg_write && (paddr[2] == REG_BASE_ADDRESS)) begin
            r_base_address <= pwdata;
        end
    end

    // Front: accept, hold one word, check the window, work out the span.
    nfa_front #(
        .BLK_BYTES   (BLK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT),
        .t_cmd       (t_cmd)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_item         (i_item),
        .i_base_address (r_base_address),
        .i_status       (w_status),
        .i_q_full       (w_q_full),
        .o_busy         (busy),
        .o_push         (w_push),
        .o_cmd          (w_front_cmd)
    );

    // Short queue so the front keeps taking words during an erase sweep.
    nfa_queue #(
        .t_cmd (t_cmd),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_back_cmd),
        .o_empty (w_q_empty),
        .o_full  (w_q_full)
    );

    // Back: owns the byte array, runs reads, programs and erase sweeps.
    nfa_back #(
        .BLK_BYTES   (BLK_BYTES),
        .BLOCK_COUNT (BLOCK_COUNT),
        .t_cmd       (t_cmd)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_back_cmd),
        .i_q_empty (w_q_empty),
        .o_pop     (w_pop),
        .o_done    (o_done),
        .o_result  (o_result),
        .o_status  (w_status)
    );

    // No result may appear during the clearing pass.
    a_no_done_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_status.clearing |-> !o_done)
        else $error("result during clearing pass");

    // A refused word never returns read data.
    a_fail_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.ok) |-> (o_result.read_data == 8'h00))
        else $error("read data on refused word");

    // Back never pops an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("pop from empty queue");

    // Front never pushes into a full queue.
    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_full)
        else $error("push into full queue");

endmodule

[sim/tb.sv]
`timescale 1ns / 100ps

module tb;
    import nfa_pkg::*;

    localparam int BLK        = DEF_BLK_BYTES;
    localparam int BLK_COUNT  = DEF_BLOCK_COUNT;
    localparam int ARRAY_SIZE = BLK * BLK_COUNT;

    // Longest legal silence is one full-array sweep plus queue slack.
    // This limit leaves several times that.
    localparam int WATCHDOG_LIMIT = 100000;
    localparam int PHASE_WORDS    = 170;
    localparam int SETTLE_CYCLES  = 8;

    localparam logic [CFG_ADDR_W-1:0] BASE_PADDR = {REG_BASE_ADDRESS, 2'b00};

    // One expected reply. A directed row may carry a typed-in value that
    // takes the place of the prediction.
    typedef struct {
        t_item   word;
        t_result want;
    } t_reply;

    typedef struct {
        t_item   word;
        bit      typed;
        t_result fixed;
    } t_row;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start   = 1'b0;
    logic                  busy;
    t_item                 i_item  = '0;
    logic                  o_done;
    t_result               o_result;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Shadow of the array and of the base register.
    logic [7:0]  cells [ARRAY_SIZE];
    logic [31:0] base_cfg = '0;

    t_reply      awaited [$];
    int          mismatches   = 0;
    int          quiet_cycles = 0;

    // Hand-off from the driver to the monitor for the word on the bus.
    bit          row_typed = 1'b0;
    t_result     row_fixed = '0;

    // Offset that the random part clusters around, so reads hit programmed
    // cells and erases hit dirty blocks.
    int unsigned hot_off = 0;

    nor_flash_array_model_core dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        foreach (cells[i]) cells[i] = ERASED_BYTE;
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one word to the shadow array and return the reply it gives.
    function automatic t_result flash_apply(input t_item w);
        t_result     r;
        logic [32:0] rel;
        bit          hit;
        int unsigned off;
        int unsigned ptr;
        int unsigned rest;
        int unsigned into;
        int unsigned span;
        r    = '0;
        rel  = {1'b0, w.address} - {1'b0, base_cfg};
        hit  = (w.address >= base_cfg) && (rel < ARRAY_SIZE);
        off  = rel[31:0];
        if (w.op == OP_ERASE_ALL) begin
            foreach (cells[i]) cells[i] = ERASED_BYTE;
            r.ok = 1'b1;
        end else if (hit) begin
            r.ok = 1'b1;
            case (w.op)
                OP_READ: begin
                    r.read_data = cells[off];
                end
                OP_PROG: begin
                    cells[off] = cells[off] & w.data;
                end
                OP_ERASE: begin
                    // Sweep whole blocks from the one holding the start;
                    // stop at the end of the array.
                    ptr  = off;
                    rest = {17'd0, w.length};
                    while (rest > 0 && ptr < ARRAY_SIZE) begin
                        into = ptr % BLK;
                        span = BLK - into;
                        for (int k = 0; k < BLK; k++) cells[ptr - into + k] = ERASED_BYTE;
                        rest = (rest <= span) ? 0 : rest - span;
                        ptr  = ptr + span;
                    end
                end
                default: begin
                end
            endcase
        end
        return r;
    endfunction

    // Monitor: retire replies first, then log any word accepted at this edge.
    always @(posedge i_clk) begin
        t_reply  head;
        t_reply  fresh;
        logic    took;
        took = i_rst_n && start && (busy === 1'b0);
        if (o_done === 1'b1) begin
            if (awaited.size() == 0) begin
                flag_mismatch("reply with nothing awaited", {23'b0, o_result}, 32'b0);
            end else begin
                head = awaited.pop_front();
                if (o_result.ok !== head.want.ok)
                    flag_mismatch($sformatf("ok (op %s addr %h)", head.word.op.name(),
                                  head.word.address), {31'b0, o_result.ok},
                                  {31'b0, head.want.ok});
                if (o_result.read_data !== head.want.read_data)
                    flag_mismatch($sformatf("read_data (op %s addr %h)",
                                  head.word.op.name(), head.word.address),
                                  {24'b0, o_result.read_data},
                                  {24'b0, head.want.read_data});
            end
        end
        if (took) begin
            fresh.word = i_item;
            fresh.want = flash_apply(i_item);
            if (row_typed) fresh.want = row_fixed;
            awaited.push_back(fresh);
        end
        if (took || o_done === 1'b1) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    // Watchdog: give up once nothing has moved for too long.
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // Present one word after a gap and hold it until the block takes it.
    // start is left high, so a zero gap on the next call keeps it up.
    task automatic issue_word(input t_item w, input int gap, input bit typed,
                              input t_result fixed);
        @(negedge i_clk);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        row_typed = typed;
        row_fixed = fixed;
        start  <= 1'b1;
        i_item <= w;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
    endtask

    // Drop start and hold until every reply is back.
    task automatic drain_replies();
        @(negedge i_clk);
        start <= 1'b0;
        while (awaited.size() != 0) @(negedge i_clk);
    endtask

    // Write the base register over the config port with the block idle,
    // then read it back.
    task automatic write_base(input logic [31:0] value);
        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= BASE_PADDR;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        base_cfg = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        if (prdata !== value) flag_mismatch("base_address readback", prdata, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_row mk_row(input t_op op, input logic [31:0] a,
                                    input logic [7:0] d, input logic [14:0] n,
                                    input bit typed, input logic ok,
                                    input logic [7:0] rd);
        t_row r;
        r.word.op        = op;
        r.word.address   = a;
        r.word.data      = d;
        r.word.length    = n;
        r.typed          = typed;
        r.fixed.ok       = ok;
        r.fixed.read_data = rd;
        return r;
    endfunction

    // Draw one random word against the current base.
    function automatic t_item draw_word();
        t_item       w;
        logic [32:0] room;
        int unsigned top;
        int unsigned off;
        int unsigned pick;
        room = 33'h1_0000_0000 - {1'b0, base_cfg};
        top  = (room < ARRAY_SIZE) ? room[31:0] - 1 : ARRAY_SIZE - 1;
        pick = $urandom_range(0, 99);
        if (pick < 70)      off = (hot_off + $urandom_range(0, 3 * BLK - 1)) % (top + 1);
        else if (pick < 85) off = $urandom_range(0, top);
        else if (pick < 90) off = ($urandom_range(0, 1) != 0) ? top : 0;
        else                off = 0;
        w.address = base_cfg + off;
        // Knock some words outside the window: just below, just past, or anywhere.
        if (pick >= 90) begin
            case ($urandom_range(0, 2))
                0:       w.address = base_cfg - 1;
                1:       w.address = base_cfg + ARRAY_SIZE;
                default: w.address = $urandom;
            endcase
        end
        pick = $urandom_range(0, 99);
        if (pick < 43)      w.op = OP_READ;
        else if (pick < 85) w.op = OP_PROG;
        else if (pick < 99) w.op = OP_ERASE;
        else                w.op = OP_ERASE_ALL;
        if ($urandom_range(0, 1) != 0) w.data = 8'($urandom_range(0, 255));
        else                           w.data = ~(8'h01 << $urandom_range(0, 7));
        // Keep sweeps short mostly; a few run to the end of the array.
        pick = $urandom_range(0, 99);
        if (pick < 40)      w.length = 15'($urandom_range(0, 16));
        else if (pick < 70) w.length = 15'($urandom_range(0, 300));
        else if (pick < 90) w.length = 15'($urandom_range(0, 600));
        else if (pick < 95) w.length = '0;
        else                w.length = 15'($urandom_range(0, 32767));
        return w;
    endfunction

    initial begin
        t_row        rows [$];
        logic [31:0] bases [6];
        int          burst_left;
        int          gap;
        burst_left = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part against the reset base of zero. The clearing pass
        // after reset simply holds the first word off.
        rows.push_back(mk_row(OP_READ,      32'd0,        8'h00, 15'd0,    1'b1, 1'b1, 8'hFF));
        rows.push_back(mk_row(OP_READ,      32'd16383,    8'h00, 15'd0,    1'b1, 1'b1, 8'hFF));
        rows.push_back(mk_row(OP_READ,      32'd16384,    8'h00, 15'd0,    1'b1, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'hFFFFFFFF, 8'hFF, 15'd0,    1'b1, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd0,        8'h00, 15'd0,    1'b1, 1'b1, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd0,        8'h00, 15'd0,    1'b1, 1'b1, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd5,        8'hA5, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd5,        8'h5A, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd5,        8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd16384,    8'h00, 15'd0,    1'b1, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_ERASE,     32'd20000,    8'h00, 15'd10,   1'b1, 1'b0, 8'h00));
        // Zero length: accepted, erases nothing.
        rows.push_back(mk_row(OP_ERASE,     32'd5,        8'h00, 15'd0,    1'b1, 1'b1, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd5,        8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd511,      8'hF0, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd512,      8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        // Two bytes straddling a block edge clear both blocks.
        rows.push_back(mk_row(OP_ERASE,     32'd255,      8'h00, 15'd2,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd0,        8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd511,      8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd512,      8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        rows.push_back(mk_row(OP_PROG,      32'd16383,    8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        // Sweep running past the end of the array.
        rows.push_back(mk_row(OP_ERASE,     32'd16383,    8'h00, 15'h7FFF, 1'b1, 1'b1, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd16383,    8'h00, 15'd0,    1'b0, 1'b0, 8'h00));
        // Erase-all ignores every other field.
        rows.push_back(mk_row(OP_ERASE_ALL, 32'hFFFFFFFF, 8'hFF, 15'h7FFF, 1'b1, 1'b1, 8'h00));
        rows.push_back(mk_row(OP_READ,      32'd512,      8'h00, 15'd0,    1'b1, 1'b1, 8'hFF));
        rows.push_back(mk_row(OP_ERASE,     32'd0,        8'h00, 15'h4000, 1'b1, 1'b1, 8'h00));

        foreach (rows[i]) issue_word(rows[i].word, $urandom_range(0, 14), rows[i].typed,
                                     rows[i].fixed);

        // Random phases: window at the top of the bus, window partly past
        // the top, a one-byte window, a random aligned and an unaligned base,
        // then back to zero.
        bases[0] = 32'hFFFF_C000;
        bases[1] = 32'hFFFF_FF00;
        bases[2] = 32'hFFFF_FFFF;
        bases[3] = $urandom & 32'hFFFF_FF00;
        bases[4] = $urandom | 32'h0000_0001;
        bases[5] = 32'h0000_0000;

        foreach (bases[p]) begin
            write_base(bases[p]);
            hot_off = $urandom_range(0, BLK_COUNT - 1) * BLK;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                if (burst_left > 0) begin
                    gap = 0;
                    burst_left--;
                end else if ($urandom_range(0, 19) == 0) begin
                    gap        = 0;
                    burst_left = $urandom_range(16, 40);
                end else begin
                    gap = $urandom_range(0, 14);
                end
                // Now and then hold off until the block has gone quiet.
                if ($urandom_range(0, 49) == 0) drain_replies();
                issue_word(draw_word(), gap, 1'b0, '0);
            end
        end

        drain_replies();
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
